// File: rtl/lcss_pkg.sv
// Shared types, constants and helpers for the LCD command stream shadow.
package lcss_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int ROWS        = 2;

  localparam logic       CMD_FEED = 1'b0;
  localparam logic       CMD_READ = 1'b1;

  localparam logic [7:0] CMD_PREFIX   = 8'hFE;
  localparam logic [7:0] CMD_SETPOS   = 8'h45;
  localparam logic [7:0] CMD_CLEAR    = 8'h51;
  localparam logic [7:0] CMD_CONTRAST = 8'h52;
  localparam logic [7:0] CMD_BRIGHT   = 8'h53;
  localparam logic [7:0] CH_LOW       = 8'h20;
  localparam logic [7:0] CH_HIGH      = 8'h7E;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NONE      = 8'h00;

  localparam logic [1:0] PS_TEXT = 2'd0;
  localparam logic [1:0] PS_CMD  = 2'd1;
  localparam logic [1:0] PS_POS  = 2'd2;
  localparam logic [1:0] PS_SKIP = 2'd3;

  typedef enum logic [3:0] {
    ST_TEXT = 4'b0001,
    ST_CMD  = 4'b0010,
    ST_POS  = 4'b0100,
    ST_SKIP = 4'b1000
  } pstate_t;

  typedef struct packed {
    logic       cursor_row;
    logic [4:0] cursor_col;
    logic [1:0] parse_state;
  } status_t;

  typedef struct packed {
    logic [7:0] cell_char;
    status_t    status;
  } result_t;

  function automatic logic [1:0] ps_code(pstate_t s);
    logic [1:0] code;
    unique case (s)
      ST_TEXT: code = PS_TEXT;
      ST_CMD:  code = PS_CMD;
      ST_POS:  code = PS_POS;
      ST_SKIP: code = PS_SKIP;
      default: code = PS_TEXT;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/lcss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lcss_parser.sv
// Stream parser: parser state, cursor registers and cell write generation.
module lcss_parser #(
  parameter int COLUMNS = lcss_pkg::COLUMNS_DEF,
  localparam int AW = $clog2(lcss_pkg::ROWS * COLUMNS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              feed,
  input  logic [7:0]        stream_byte,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output logic              clr,
  output lcss_pkg::status_t status
);
  import lcss_pkg::*;

  localparam int CW = $clog2(COLUMNS + 1);

  pstate_t         st_r, st_nxt;
  logic            row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [CW-1:0]   pos_col;
  logic [5:0]      pos_arg;
  logic            col_open;
  logic            printable;
  logic [CW+4:0]   col_ext;

  assign pos_arg   = stream_byte[5:0];
  assign pos_col   = (int'(pos_arg) > COLUMNS - 1) ? CW'(COLUMNS - 1) : CW'(pos_arg);
  assign col_open  = int'(col_r) < COLUMNS;
  assign printable = (stream_byte >= CH_LOW) && (stream_byte <= CH_HIGH);
  assign wr_addr   = (row_r ? AW'(COLUMNS) : AW'(0)) + AW'(col_r);
  assign wr_data   = stream_byte;

  always_comb begin
    st_nxt  = st_r;
    row_nxt = row_r;
    col_nxt = col_r;
    wr_en   = 1'b0;
    clr     = 1'b0;
    if (feed) begin
      unique case (st_r)
        ST_TEXT: begin
          if (stream_byte == CMD_PREFIX) begin
            st_nxt = ST_CMD;
          end else if (printable && col_open) begin
            wr_en   = 1'b1;
            col_nxt = col_r + CW'(1);
          end
        end
        ST_CMD: begin
          if (stream_byte == CMD_SETPOS) begin
            st_nxt = ST_POS;
          end else if (stream_byte == CMD_CLEAR) begin
            clr     = 1'b1;
            row_nxt = 1'b0;
            col_nxt = '0;
            st_nxt  = ST_TEXT;
          end else if (stream_byte == CMD_CONTRAST || stream_byte == CMD_BRIGHT) begin
            st_nxt = ST_SKIP;
          end else begin
            st_nxt = ST_TEXT;
          end
        end
        ST_POS: begin
          row_nxt = stream_byte[7] | stream_byte[6];
          col_nxt = pos_col;
          st_nxt  = ST_TEXT;
        end
        ST_SKIP: st_nxt = ST_TEXT;
        default: st_nxt = ST_TEXT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_TEXT;
      row_r <= 1'b0;
      col_r <= '0;
    end else begin
      st_r  <= st_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign col_ext            = {5'b0, col_r};
  assign status.cursor_row  = row_r;
  assign status.cursor_col  = col_ext[4:0];
  assign status.parse_state = ps_code(st_r);

endmodule

// File: rtl/lcss_cells.sv
// Screen shadow store: cell RAM, per-cell valid bits and registered cell read.
module lcss_cells #(
  parameter int COLUMNS = lcss_pkg::COLUMNS_DEF,
  localparam int AW = $clog2(lcss_pkg::ROWS * COLUMNS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          clr,
  input  logic          rd_en,
  input  logic          rd_row,
  input  logic [3:0]    rd_col,
  output logic [7:0]    rd_char
);
  import lcss_pkg::*;

  localparam int DEPTH = ROWS * COLUMNS;

  logic [DEPTH-1:0] vld_r;
  logic             rd_ok;
  logic [AW-1:0]    rd_addr;
  logic             rd_vld_r;
  logic             rd_ok_r;
  logic [7:0]       ram_q;

  assign rd_ok   = int'(rd_col) < COLUMNS;
  assign rd_addr = rd_ok ? ((rd_row ? AW'(COLUMNS) : AW'(0)) + AW'(rd_col)) : AW'(0);

  lcss_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
      rd_ok_r  <= rd_ok;
    end
  end

  assign rd_char = (rd_ok_r && rd_vld_r) ? ram_q : CH_SPACE;

endmodule

// File: rtl/lcss_out_queue.sv
// Two-entry result queue between the working stage and the result channel.
module lcss_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcss_pkg::result_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              valid,
  output lcss_pkg::result_t head
);
  import lcss_pkg::*;

  result_t    ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/lcd_command_stream_shadow.sv
// Top level of the LCD command stream shadow.
//
// Snoops the byte stream of a serial character LCD and keeps a shadow of its
// screen. Input channel (in_valid/in_stall): in_cmd 0 feeds in_stream_byte
// to the parser, in_cmd 1 reads the cell at in_cell_row/in_cell_col.
// Result channel (out_valid/out_stall): one transaction per input, carrying
// the cell character (0 on a feed), cursor row/column and parser state as
// they stand after that input.
// Path: the parser update and cell RAM read land at the accepting edge,
// together with the working stage; from there the result enters the result
// queue, whose head drives the result channel.
// Throughput: one transaction per cycle while in_stall is low, set by the
// parser update and the one write / one read port of the cell RAM.
// Reset: synchronous, active low; the parser returns to text, the cursor
// homes and all cell valid bits drop, so every cell reads as a space.
// Stall: results collect in a two-entry queue; in_stall rises only when the
// queue is full and a finished transaction waits in the working stage.
module lcd_command_stream_shadow #(
  parameter int COLUMNS = lcss_pkg::COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_stream_byte,
  input  logic       in_cell_row,
  input  logic [3:0] in_cell_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_cell_char,
  output logic       out_cursor_row,
  output logic [4:0] out_cursor_col,
  output logic [1:0] out_parse_state
);
  import lcss_pkg::*;

  localparam int AW = $clog2(ROWS * COLUMNS);

  logic          accept;
  logic          feed;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          clr;
  status_t       status;
  logic [7:0]    rd_char;
  logic          s1_vld_r, s1_vld_nxt;
  logic          s1_read_r;
  logic          q_full;
  logic          push;
  logic          pop;
  result_t       res;
  result_t       head;

  assign in_stall = s1_vld_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign feed     = accept & (in_cmd == CMD_FEED);
  assign rd_en    = accept & (in_cmd == CMD_READ);

  lcss_parser #(
    .COLUMNS (COLUMNS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .feed        (feed),
    .stream_byte (in_stream_byte),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .clr         (clr),
    .status      (status)
  );

  lcss_cells #(
    .COLUMNS (COLUMNS)
  ) u_cells (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .clr     (clr),
    .rd_en   (rd_en),
    .rd_row  (in_cell_row),
    .rd_col  (in_cell_col),
    .rd_char (rd_char)
  );

  assign push = s1_vld_r & ~q_full;
  assign pop  = out_valid & ~out_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (push) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read_r <= in_cmd == CMD_READ;
    end
  end

  assign res.cell_char = s1_read_r ? rd_char : CH_NONE;
  assign res.status    = status;

  lcss_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .pop       (pop),
    .full      (q_full),
    .valid     (out_valid),
    .head      (head)
  );

  assign out_cell_char   = head.cell_char;
  assign out_cursor_row  = head.status.cursor_row;
  assign out_cursor_col  = head.status.cursor_col;
  assign out_parse_state = head.status.parse_state;

endmodule

// File: rtl/lcss_checker.sv
// Port-level checks on the LCD command stream shadow, bound to the top level.
module lcss_checker #(
  parameter int COLUMNS = lcss_pkg::COLUMNS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_cmd,
  input logic [7:0] in_stream_byte,
  input logic       in_cell_row,
  input logic [3:0] in_cell_col,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_cell_char,
  input logic       out_cursor_row,
  input logic [4:0] out_cursor_col,
  input logic [1:0] out_parse_state
);
  import lcss_pkg::*;

  localparam logic [4:0] COL_MAX = 5'(COLUMNS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_char)
      && $stable(out_cursor_col))
    else $error("stalled result changed");

  a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (COLUMNS > 31) || (out_cursor_col <= COL_MAX))
    else $error("cursor column beyond line end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending after reset");

endmodule

bind lcd_command_stream_shadow lcss_checker #(.COLUMNS(COLUMNS)) u_lcss_checker (.*);
